>>> hdl/dcr_pkg.sv
// dcr_pkg: shared types and constants of the depth-to-color registration block.
// No dependencies; used by dcr_mac, dcr_div and depth_to_color_registration.
package dcr_pkg;

    localparam int ACC_W   = 64;   // Q48.16 mm accumulator
    localparam int MUL_A_W = 46;   // wide multiplier operand (sum of col/row terms)
    localparam int MUL_B_W = 17;   // narrow multiplier operand (col, row or depth)
    localparam int COORD_W = 14;   // target coordinate with room for a -1 underflow

    // configuration register indexes
    localparam logic [2:0] REG_X_AB   = 3'd0;
    localparam logic [2:0] REG_X_CT   = 3'd1;
    localparam logic [2:0] REG_Y_AB   = 3'd2;
    localparam logic [2:0] REG_Y_CT   = 3'd3;
    localparam logic [2:0] REG_Z_AB   = 3'd4;
    localparam logic [2:0] REG_Z_CT   = 3'd5;
    localparam logic [2:0] REG_DILATE = 3'd6;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,     // acc = prod
        ACC_ADD_PC,   // acc = acc + prod + c
        ACC_ADD_C     // acc = prod + c
    } acc_op_t;

    typedef struct packed {
        logic    mul_en;
        acc_op_t acc_op;
    } mac_ctl_t;

endpackage

>>> hdl/dcr_mac.sv
// dcr_mac: shared multiply / accumulate unit, one product register and one accumulator.
// Depends on dcr_pkg.
module dcr_mac
    import dcr_pkg::*;
(
    input  logic                        clk,
    input  mac_ctl_t                    ctl,
    input  logic signed [MUL_A_W-1:0]   mul_a,
    input  logic signed [MUL_B_W-1:0]   mul_b,
    input  logic signed [ACC_W-1:0]     add_c,
    output logic signed [ACC_W-1:0]     acc
);

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [MUL_A_W+MUL_B_W-1:0] prod_full;

    // full-width signed product, no bits lost before the register
    assign prod_full = mul_a * mul_b;

    always_comb
    begin
        case (ctl.acc_op)
            ACC_LOAD:   acc_next = prod_reg;
            ACC_ADD_PC: acc_next = acc_reg + prod_reg + add_c;
            ACC_ADD_C:  acc_next = prod_reg + add_c;
            default:    acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= ACC_W'(prod_full);
        end
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

>>> hdl/dcr_div.sv
// dcr_div: restoring divider, one quotient bit a cycle, with range rejection.
// floor(num/den) if 0 <= num < den*2^QB, else ok low; den < 0 unchecked. Uses dcr_pkg.
module dcr_div
    import dcr_pkg::*;
#(
    parameter int QB = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] num,
    input  logic signed [ACC_W-1:0] den,
    output logic                    done,
    output logic                    ok,
    output logic [QB-1:0]           quot
);

    localparam int CNT_W = $clog2(QB + 1);
    localparam int DSR_W = ACC_W + QB;

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHECK,
        D_RUN
    } div_state_t;

    div_state_t         state_reg, state_next;
    logic [ACC_W-1:0]   rem_reg, rem_next;
    logic [DSR_W-1:0]   dsr_reg, dsr_next;
    logic [QB-1:0]      q_reg, q_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic               ok_reg, ok_next;
    logic               fits;

    assign fits = DSR_W'(rem_reg) >= dsr_reg;

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    rem_next = ACC_W'(num);
                    dsr_next = DSR_W'(ACC_W'(den)) << QB;
                    q_next   = '0;
                    if (num[ACC_W-1])
                    begin
                        done_next = 1'b1;
                        ok_next   = 1'b0;
                    end
                    else
                    begin
                        state_next = D_CHECK;
                    end
                end
            end
            D_CHECK:
            begin
                if (fits)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b0;
                    state_next = D_IDLE;
                end
                else
                begin
                    dsr_next   = dsr_reg >> 1;
                    cnt_next   = CNT_W'(QB);
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (fits)
                begin
                    rem_next = rem_reg - ACC_W'(dsr_reg);
                end
                q_next   = (q_reg << 1) | QB'(fits);
                dsr_next = dsr_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign ok   = ok_reg;
    assign quot = q_reg;

endmodule

>>> hdl/depth_to_color_registration.sv
// depth_to_color_registration: z-buffered scatter of depth pixels into the color view.
// Depends on dcr_pkg, dcr_mac (shared multiply/accumulate) and dcr_div (divider).
//
//  channel   dir  handshake            payload
//  input     in   in_valid/in_ready    mode, pixel_column, pixel_row, depth_mm
//  output    out  out_valid/out_ready  registered_depth
//  config    in   APB psel/penable     paddr, pwdata, prdata (64-bit registers at 8*i)
//
// Scatter: 3 axes on the shared multiplier, two divisions (QB = clog2 of the larger image
// side), then a z-buffer read-modify-write per target on the single memory port (1 target,
// 4 with dilation).
// Readout: S_ADDR, S_READ, S_UPD, plus any wait for the output register to free up.
// After reset a clearing pass writes zero to all IMAGE_WIDTH*IMAGE_HEIGHT entries, one a
// cycle; no beat is taken meanwhile, config writes are.
// in_ready is high only between items; a held output beat stalls only the next readout.
module depth_to_color_registration
    import dcr_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [9:0]  pixel_column,
    input  logic [8:0]  pixel_row,
    input  logic [15:0] depth_mm,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] registered_depth,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int NPIX = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int AW   = $clog2(NPIX);
    localparam int XB   = $clog2(IMAGE_WIDTH);
    localparam int YB   = $clog2(IMAGE_HEIGHT);
    localparam int QB   = (XB > YB) ? XB : YB;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MAC,
        S_AXIS,
        S_DIVX,
        S_DIVXW,
        S_DIVY,
        S_DIVYW,
        S_ADDR,
        S_READ,
        S_UPD
    } state_t;

    typedef enum logic [1:0] {
        AX_Z,
        AX_X,
        AX_Y
    } axis_t;

    state_t             state_reg;
    axis_t              axis_reg;
    logic [2:0]         step_reg;
    logic               mode_reg;
    logic [9:0]         col_reg;
    logic [8:0]         row_reg;
    logic [15:0]        depth_reg;
    logic signed [ACC_W-1:0] z_reg, x_reg, y_reg;
    logic [15:0]        v_reg;
    logic [QB-1:0]      px_reg, py_reg;
    logic [1:0]         tgt_reg;
    logic [AW-1:0]      addr_reg;
    logic               tv_reg;
    logic [AW-1:0]      clr_reg;
    logic               out_valid_reg;
    logic [15:0]        out_data_reg;
    logic [63:0]        x_ab_reg, x_ct_reg, y_ab_reg, y_ct_reg, z_ab_reg, z_ct_reg;
    logic               dilate_reg;

    logic [15:0]        mem [NPIX];
    logic [15:0]        rd_data_reg;

    // shared unit hookup
    mac_ctl_t                   mac_ctl;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]    add_c;
    logic signed [ACC_W-1:0]    acc;
    logic [63:0]                ab_sel, ct_sel;

    logic                       div_start, div_done, div_ok;
    logic [QB-1:0]              div_q;
    logic signed [ACC_W-1:0]    div_num, div_den;

    logic [COORD_W-1:0]         tx, ty;
    logic                       t_in;
    logic [AW-1:0]              t_addr;
    logic                       slot_free;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [15:0]                wr_data;
    logic                       cfg_wr;
    logic                       z_drop;
    logic                       last_tgt;

    always_comb
    begin
        unique case (axis_reg)
            AX_X:    begin ab_sel = x_ab_reg; ct_sel = x_ct_reg; end
            AX_Y:    begin ab_sel = y_ab_reg; ct_sel = y_ct_reg; end
            default: begin ab_sel = z_ab_reg; ct_sel = z_ct_reg; end
        endcase
    end

    // per axis: a*col, b*row, sum + c, d*sum, + t
    always_comb
    begin
        mac_ctl.mul_en = 1'b0;
        mac_ctl.acc_op = ACC_HOLD;
        mul_a          = MUL_A_W'($signed(ab_sel[31:0]));
        mul_b          = $signed({7'd0, col_reg});
        add_c          = ACC_W'($signed(ct_sel[31:0]));
        if (state_reg == S_MAC)
        begin
            case (step_reg)
                3'd0: mac_ctl.mul_en = 1'b1;
                3'd1:
                begin
                    mac_ctl.mul_en = 1'b1;
                    mac_ctl.acc_op = ACC_LOAD;
                    mul_a          = MUL_A_W'($signed(ab_sel[63:32]));
                    mul_b          = $signed({8'd0, row_reg});
                end
                3'd2: mac_ctl.acc_op = ACC_ADD_PC;
                3'd3:
                begin
                    mac_ctl.mul_en = 1'b1;
                    mul_a          = acc[MUL_A_W-1:0];
                    mul_b          = $signed({1'b0, depth_reg});
                end
                default:
                begin
                    mac_ctl.acc_op = ACC_ADD_C;
                    add_c          = ACC_W'($signed(ct_sel[63:32]));
                end
            endcase
        end
    end

    dcr_mac u_mac (
        .clk   (clk),
        .ctl   (mac_ctl),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .add_c (add_c),
        .acc   (acc)
    );

    // round to nearest: floor((2X+Z)/(2Z))
    assign div_start = (state_reg == S_DIVX) || (state_reg == S_DIVY);
    assign div_num   = ((state_reg == S_DIVY) ? (y_reg <<< 1) : (x_reg <<< 1)) + z_reg;
    assign div_den   = z_reg <<< 1;

    dcr_div #(.QB(QB)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .ok    (div_ok),
        .quot  (div_q)
    );

    assign z_drop = acc[ACC_W-1] || (acc[ACC_W-1:16] == '0);

    // target pixel; a neighbour at -1 wraps high and falls off the image
    always_comb
    begin
        if (mode_reg)
        begin
            tx = COORD_W'(col_reg);
            ty = COORD_W'(row_reg);
        end
        else
        begin
            tx = COORD_W'(px_reg) - COORD_W'(tgt_reg[0]);
            ty = COORD_W'(py_reg) - COORD_W'(tgt_reg[1]);
        end
    end

    assign t_in   = (tx < COORD_W'(IMAGE_WIDTH)) && (ty < COORD_W'(IMAGE_HEIGHT));
    assign t_addr = AW'(ty) * AW'(IMAGE_WIDTH) + AW'(tx);

    assign slot_free = !out_valid_reg || out_ready;
    assign last_tgt  = !dilate_reg || (tgt_reg == 2'd3);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
        end
        else if (state_reg == S_UPD && tv_reg)
        begin
            if (mode_reg)
            begin
                wr_en = slot_free;
            end
            else
            begin
                wr_en   = (rd_data_reg == '0) || (rd_data_reg > v_reg);
                wr_data = v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    // sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            axis_reg      <= AX_Z;
            step_reg      <= '0;
            tgt_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a readout finishing this cycle reloads the slot below
            if (out_valid_reg && out_ready && !(state_reg == S_UPD && mode_reg))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(NPIX - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        axis_reg <= AX_Z;
                        step_reg <= '0;
                        tgt_reg  <= '0;
                        if (mode)
                        begin
                            state_reg <= S_ADDR;
                        end
                        else if (depth_mm != '0)
                        begin
                            state_reg <= S_MAC;
                        end
                    end
                end
                S_MAC:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd4)
                    begin
                        state_reg <= S_AXIS;
                    end
                end
                S_AXIS:
                begin
                    step_reg  <= '0;
                    state_reg <= S_MAC;
                    unique case (axis_reg)
                        AX_Z:
                        begin
                            axis_reg <= AX_X;
                            if (z_drop)
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                        AX_X: axis_reg <= AX_Y;
                        default: state_reg <= S_DIVX;
                    endcase
                end
                S_DIVX: state_reg <= S_DIVXW;
                S_DIVXW:
                begin
                    if (div_done)
                    begin
                        if (div_ok && ({1'b0, div_q} < (QB + 1)'(IMAGE_WIDTH)))
                        begin
                            state_reg <= S_DIVY;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_DIVY: state_reg <= S_DIVYW;
                S_DIVYW:
                begin
                    if (div_done)
                    begin
                        if (div_ok && ({1'b0, div_q} < (QB + 1)'(IMAGE_HEIGHT)))
                        begin
                            state_reg <= S_ADDR;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_ADDR: state_reg <= S_READ;
                S_READ: state_reg <= S_UPD;
                S_UPD:
                begin
                    if (mode_reg)
                    begin
                        if (slot_free)
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                    else if (last_tgt)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        tgt_reg   <= tgt_reg + 1'b1;
                        state_reg <= S_ADDR;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            mode_reg  <= mode;
            col_reg   <= pixel_column;
            row_reg   <= pixel_row;
            depth_reg <= depth_mm;
        end
        if (state_reg == S_AXIS)
        begin
            unique case (axis_reg)
                AX_Z:
                begin
                    z_reg <= acc;
                    v_reg <= (acc[ACC_W-1:32] != '0) ? 16'hFFFF : acc[31:16];
                end
                AX_X:    x_reg <= acc;
                default: y_reg <= acc;
            endcase
        end
        if (state_reg == S_DIVXW && div_done)
        begin
            px_reg <= div_q;
        end
        if (state_reg == S_DIVYW && div_done)
        begin
            py_reg <= div_q;
        end
        if (state_reg == S_ADDR)
        begin
            addr_reg <= t_addr;
            tv_reg   <= t_in;
        end
        if (state_reg == S_UPD && mode_reg && slot_free)
        begin
            out_data_reg <= tv_reg ? rd_data_reg : 16'd0;
        end
    end

    // configuration registers
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_ab_reg   <= '0;
            x_ct_reg   <= '0;
            y_ab_reg   <= '0;
            y_ct_reg   <= '0;
            z_ab_reg   <= '0;
            z_ct_reg   <= '0;
            dilate_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[5:3])
                REG_X_AB:   x_ab_reg   <= pwdata;
                REG_X_CT:   x_ct_reg   <= pwdata;
                REG_Y_AB:   y_ab_reg   <= pwdata;
                REG_Y_CT:   y_ct_reg   <= pwdata;
                REG_Z_AB:   z_ab_reg   <= pwdata;
                REG_Z_CT:   z_ct_reg   <= pwdata;
                REG_DILATE: dilate_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            REG_X_AB:   prdata = x_ab_reg;
            REG_X_CT:   prdata = x_ct_reg;
            REG_Y_AB:   prdata = y_ab_reg;
            REG_Y_CT:   prdata = y_ct_reg;
            REG_Z_AB:   prdata = z_ab_reg;
            REG_Z_CT:   prdata = z_ct_reg;
            REG_DILATE: prdata = {63'd0, dilate_reg};
            default:    prdata = '0;
        endcase
    end

    assign pready           = 1'b1;
    assign in_ready         = (state_reg == S_IDLE);
    assign out_valid        = out_valid_reg;
    assign registered_depth = out_data_reg;

    // clearing pass writes only zeros
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (wr_en && wr_data == 16'd0))
        else $error("clearing pass wrote nonzero");

    // a scatter never stores an empty depth
    a_scatter_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg == S_UPD && !mode_reg) |-> (wr_data != 16'd0))
        else $error("scatter wrote zero depth");

    // an output beat only comes from a finished readout
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_UPD && mode_reg))
        else $error("output beat without readout");

    // divider results are only awaited where a division was started
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVXW || state_reg == S_DIVYW))
        else $error("divider done out of sequence");

endmodule
